### rtl/bax_pkg.sv
// Shared types and constants for the button and axis qualifier.
// Holds the transfer payload structs, register indexes and field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bax_pkg;

  // Number of channels that keep per-channel state.
  localparam int unsigned Channels = 32;
  localparam int unsigned ChanIdxW = (Channels > 1) ? $clog2(Channels) : 1;

  localparam int unsigned ChanW   = 5;
  localparam int unsigned SampleW = 16;
  localparam int unsigned DeltaW  = 32;
  localparam int unsigned CountW  = 16;
  localparam int unsigned HeldW   = 48;
  localparam int unsigned MaskW   = 32;
  localparam int unsigned LevelW  = 15;
  localparam int unsigned CfgAddrW = 1;
  localparam int unsigned CfgDataW = 32;

  // Configuration register indexes.
  localparam logic [CfgAddrW-1:0] RegDeadbandMask  = 1'd0;
  localparam logic [CfgAddrW-1:0] RegDeadbandLevel = 1'd1;

  // Button sample value that counts as fully pressed.
  localparam logic signed [SampleW-1:0] FullScale = 16'sd16384;

  typedef struct packed {
    logic [ChanW-1:0]          channel;
    logic signed [SampleW-1:0] sample;
    logic [DeltaW-1:0]         delta_ns;
  } in_item_t;

  typedef struct packed {
    logic [ChanW-1:0]          channel_out;
    logic signed [SampleW-1:0] value_out;
    logic                      toggle;
    logic [CountW-1:0]         press_count;
    logic [HeldW-1:0]          held_ns;
    logic                      rising;
    logic                      falling;
  } out_item_t;

  // Configuration values seen by the datapath.
  typedef struct packed {
    logic [MaskW-1:0]  deadband_mask;
    logic [LevelW-1:0] deadband_level;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/bax_core.sv
// Per-channel state table and qualification logic for one sample.
// Computes the result from the current state and commits the update on commit_i.
// Depends on bax_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bax_core (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  bax_pkg::cfg_t     cfg_i,
  input  bax_pkg::in_item_t item_i,
  input  wire               commit_i,
  output bax_pkg::out_item_t result_o
);
  import bax_pkg::*;

  logic signed [SampleW-1:0] last_raw_q [Channels];
  logic                      toggle_q   [Channels];
  logic [CountW-1:0]         count_q    [Channels];
  logic [HeldW-1:0]          held_q     [Channels];

  logic                      in_range;
  logic [ChanIdxW-1:0]       idx;
  logic signed [SampleW-1:0] prev;
  logic                      rise;
  logic                      fall;
  logic                      same;
  logic                      toggle_d;
  logic [CountW-1:0]         count_d;
  logic [HeldW:0]            held_sum;
  logic [HeldW-1:0]          held_d;
  logic [SampleW:0]          sample_ext;
  logic [SampleW:0]          mag;
  logic                      zero_out;

  assign in_range = (32'(item_i.channel) < Channels);
  assign idx      = ChanIdxW'(item_i.channel);
  assign prev     = last_raw_q[idx];

  // Edge detection on raw values.
  assign rise = (prev == '0) && (item_i.sample == FullScale);
  assign fall = (prev == FullScale) && (item_i.sample == '0);
  assign same = (prev == item_i.sample);

  assign toggle_d = toggle_q[idx] ^ rise;
  assign count_d  = count_q[idx] + CountW'(rise);

  // Held time accumulates while unchanged and saturates on carry out.
  assign held_sum = {1'b0, held_q[idx]} + (HeldW + 1)'(item_i.delta_ns);
  always_comb begin
    if (!same) begin
      held_d = '0;
    end else if (held_sum[HeldW]) begin
      held_d = '1;
    end else begin
      held_d = held_sum[HeldW-1:0];
    end
  end

  // Deadband zeroing on the exact magnitude of the sample.
  assign sample_ext = {item_i.sample[SampleW-1], item_i.sample};
  assign mag        = item_i.sample[SampleW-1] ? (~sample_ext + (SampleW + 1)'(1))
                                               : sample_ext;
  assign zero_out   = cfg_i.deadband_mask[item_i.channel] &&
                      (mag <= (SampleW + 1)'(cfg_i.deadband_level));

  always_comb begin
    result_o.channel_out = item_i.channel;
    result_o.value_out   = zero_out ? '0 : item_i.sample;
    result_o.toggle      = in_range & toggle_d;
    result_o.press_count = in_range ? count_d : '0;
    result_o.held_ns     = in_range ? held_d : '0;
    result_o.rising      = in_range & rise;
    result_o.falling     = in_range & fall;
  end

  // State update when the result moves into the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Channels; i++) begin
        last_raw_q[i] <= '0;
        toggle_q[i]   <= 1'b0;
        count_q[i]    <= '0;
        held_q[i]     <= '0;
      end
    end else if (commit_i && in_range) begin
      last_raw_q[idx] <= item_i.sample;
      toggle_q[idx]   <= toggle_d;
      count_q[idx]    <= count_d;
      held_q[idx]     <= held_d;
    end
  end

endmodule

`default_nettype wire

### rtl/button_axis_qualifier.sv
// Button and axis qualifier: edge, toggle, press count, held time, deadband.
//
// Usage:
// - Input channel (in_valid_i / in_ready_o / in_data_i) carries one sample of
//   one channel per transfer. Output channel (out_valid_o / out_ready_i /
//   out_data_o) carries exactly one result per input transfer, in order.
// - An accepted sample sits in an input register; when the output register is
//   empty or being drained, the per-channel state is read, updated and the
//   result is loaded into the output register along with output valid.
// - Throughput is one sample per cycle while the receiver does not stall, also
//   for repeated reports of the same channel, since the state update lands in
//   the same edge the next sample is read after it.
// - When the receiver stalls, the output register holds its result, the
//   input register fills, and in_ready_o drops until the output drains.
// - Reset clears all per-channel state, both configuration registers and
//   both valid flags; there is no clearing pass.
// - Configuration writes (cfg_we_i, cfg_addr_i, cfg_data_i) take effect at
//   once and are to be issued only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module button_axis_qualifier (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  wire [bax_pkg::CfgAddrW-1:0]       cfg_addr_i,
  input  wire [bax_pkg::CfgDataW-1:0]       cfg_data_i,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  bax_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output bax_pkg::out_item_t                out_data_o
);
  import bax_pkg::*;

  cfg_t      cfg_q;
  in_item_t  item_q;
  logic      item_valid_q;
  out_item_t result;
  out_item_t out_q;
  logic      out_valid_q;
  logic      out_load;
  logic      item_load;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegDeadbandMask:  cfg_q.deadband_mask  <= cfg_data_i[MaskW-1:0];
        RegDeadbandLevel: cfg_q.deadband_level <= cfg_data_i[LevelW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the output register loads when empty or being drained.
  assign out_load   = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || out_load;
  assign item_load  = in_valid_i && in_ready_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_load) begin
      item_q <= in_data_i;
    end
  end

  bax_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .item_i   (item_q),
    .commit_i (out_load),
    .result_o (result)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
